// ===== rtl/ppmp6_pkg.sv =====
// ----------------------------------------------------------------------------
// PPM P6 header parser package
// Shared constants and types for the binary PPM header parser.
// ----------------------------------------------------------------------------
package ppmp6_pkg;

  localparam int unsigned DIM_BITS_DEF = 16;
  localparam int unsigned IMG_DIM_W    = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned OUT_DATA_W   = 2 * IMG_DIM_W + 3 * BYTE_W;

  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_SKIP1   = 4'd2,
    PH_CHECK   = 4'd3,
    PH_COMMENT = 4'd4,
    PH_WIDTH   = 4'd5,
    PH_HEIGHT  = 4'd6,
    PH_MAXVAL  = 4'd7,
    PH_PIXELS  = 4'd8
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CI_RED   = 2'd0,
    CI_GREEN = 2'd1,
    CI_BLUE  = 2'd2
  } color_e;

endpackage

// ===== rtl/ppmp6_dec_acc.sv =====
// ----------------------------------------------------------------------------
// PPM P6 decimal accumulator
// Folds one ASCII byte into a saturating decimal value; the first non-digit
// ends the number and later bytes leave it unchanged.
// ----------------------------------------------------------------------------
module ppmp6_dec_acc #(
  parameter int unsigned DIM_BITS = ppmp6_pkg::DIM_BITS_DEF
) (
  input  logic [DIM_BITS-1:0]           acc_i,
  input  logic                          ended_i,
  input  logic [ppmp6_pkg::BYTE_W-1:0]  byte_i,
  output logic [DIM_BITS-1:0]           acc_o,
  output logic                          ended_o
);

  localparam int unsigned SUM_W = DIM_BITS + 4;

  logic              is_digit;
  logic [SUM_W-1:0]  acc_ext;
  logic [SUM_W-1:0]  digit_ext;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  dim_max_ext;

  assign is_digit    = (byte_i >= ppmp6_pkg::CH_ZERO) && (byte_i <= ppmp6_pkg::CH_NINE);
  assign acc_ext     = SUM_W'(acc_i);
  assign digit_ext   = SUM_W'(byte_i - ppmp6_pkg::CH_ZERO);
  assign sum         = (acc_ext << 3) + (acc_ext << 1) + digit_ext;
  assign dim_max_ext = SUM_W'({DIM_BITS{1'b1}});

  always_comb begin
    acc_o   = acc_i;
    ended_o = ended_i;
    if (!ended_i) begin
      if (!is_digit) begin
        ended_o = 1'b1;
      end else if (sum > dim_max_ext) begin
        acc_o = {DIM_BITS{1'b1}};
      end else begin
        acc_o = sum[DIM_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/ppm_p6_header_parser.sv =====
// ----------------------------------------------------------------------------
// PPM P6 header parser
// Parses a binary PPM stream byte by byte, reports the header and groups the
// pixel bytes into RGB beats.
//
//   Channel  Dir  tdata (low to high)                          tuser  tlast
//   s_axis   in   data_byte[7:0]                               -      -
//   m_axis   out  width[15:0] height[15:0] red green blue      kind   last_pixel
//
// A new input beat can be taken every cycle while s_axis_tready is high. A
// result appears on m_axis the cycle after the beat that causes it, held in
// a single output register. s_axis_tready drops only while that register is
// full and m_axis_tready is low. Reset returns the parser to waiting for the
// first magic byte with no pending result.
// ----------------------------------------------------------------------------
module ppm_p6_header_parser #(
  parameter int unsigned DIM_BITS = ppmp6_pkg::DIM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte[7:0]
  input  logic [ppmp6_pkg::BYTE_W-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // image_width[15:0], image_height[31:16], red[39:32], green[47:40], blue[55:48]
  output logic [ppmp6_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind[1:0]
  output logic [ppmp6_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int unsigned BW = ppmp6_pkg::BYTE_W;
  localparam int unsigned DW = ppmp6_pkg::IMG_DIM_W;

  ppmp6_pkg::phase_e  phase_q, phase_d;
  ppmp6_pkg::color_e  color_q, color_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic                ended_q, ended_d;
  logic [BW-1:0]       held_red_q, held_red_d;
  logic [BW-1:0]       held_green_q, held_green_d;

  logic [BW-1:0]       in_byte;
  logic                in_fire;

  logic [DIM_BITS-1:0] acc_in;
  logic                acc_ended_in;
  logic [DIM_BITS-1:0] acc_next;
  logic                acc_ended_next;

  logic                end_col;
  logic                end_row;
  logic                last_pix;
  logic                dims_zero;

  logic                res_valid;
  ppmp6_pkg::kind_e    res_kind;
  logic [DW-1:0]       res_width;
  logic [DW-1:0]       res_height;
  logic [BW-1:0]       res_red;
  logic [BW-1:0]       res_green;
  logic [BW-1:0]       res_blue;
  logic                res_last;

  logic                out_valid_q;
  ppmp6_pkg::kind_e    out_kind_q;
  logic [DW-1:0]       out_width_q;
  logic [DW-1:0]       out_height_q;
  logic [BW-1:0]       out_red_q;
  logic [BW-1:0]       out_green_q;
  logic [BW-1:0]       out_blue_q;
  logic                out_last_q;

  assign in_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign end_col   = ({1'b0, col_q} + 1'b1) >= {1'b0, width_q};
  assign end_row   = ({1'b0, row_q} + 1'b1) >= {1'b0, height_q};
  assign last_pix  = end_col && end_row;
  assign dims_zero = (width_q == '0) || (height_q == '0);

  always_comb begin
    unique case (phase_q)
      ppmp6_pkg::PH_WIDTH: begin
        acc_in       = width_q;
        acc_ended_in = ended_q;
      end
      ppmp6_pkg::PH_HEIGHT: begin
        acc_in       = height_q;
        acc_ended_in = ended_q;
      end
      default: begin
        acc_in       = '0;
        acc_ended_in = 1'b0;
      end
    endcase
  end

  ppmp6_dec_acc #(
    .DIM_BITS (DIM_BITS)
  ) u_dec_acc (
    .acc_i   (acc_in),
    .ended_i (acc_ended_in),
    .byte_i  (in_byte),
    .acc_o   (acc_next),
    .ended_o (acc_ended_next)
  );

  // Next state of the parser.
  always_comb begin
    phase_d      = phase_q;
    color_d      = color_q;
    width_d      = width_q;
    height_d     = height_q;
    col_d        = col_q;
    row_d        = row_q;
    ended_d      = ended_q;
    held_red_d   = held_red_q;
    held_green_d = held_green_q;
    unique case (phase_q)
      ppmp6_pkg::PH_MAGIC0: begin
        held_red_d = in_byte;
        phase_d    = ppmp6_pkg::PH_MAGIC1;
      end
      ppmp6_pkg::PH_MAGIC1: begin
        if (held_red_q != ppmp6_pkg::CH_P || in_byte != ppmp6_pkg::CH_SIX) begin
          phase_d  = ppmp6_pkg::PH_MAGIC0;
          width_d  = '0;
          height_d = '0;
          ended_d  = 1'b0;
          col_d    = '0;
          row_d    = '0;
          color_d  = ppmp6_pkg::CI_RED;
        end else begin
          phase_d = ppmp6_pkg::PH_SKIP1;
        end
      end
      ppmp6_pkg::PH_SKIP1, ppmp6_pkg::PH_COMMENT: begin
        if (in_byte == ppmp6_pkg::CH_LF) begin
          phase_d = ppmp6_pkg::PH_CHECK;
        end
      end
      ppmp6_pkg::PH_CHECK: begin
        if (in_byte == ppmp6_pkg::CH_HASH) begin
          phase_d = ppmp6_pkg::PH_COMMENT;
        end else if (in_byte == ppmp6_pkg::CH_SPACE) begin
          phase_d  = ppmp6_pkg::PH_HEIGHT;
          width_d  = '0;
          height_d = '0;
          ended_d  = 1'b0;
        end else begin
          phase_d = ppmp6_pkg::PH_WIDTH;
          width_d = acc_next;
          ended_d = acc_ended_next;
        end
      end
      ppmp6_pkg::PH_WIDTH: begin
        if (in_byte == ppmp6_pkg::CH_SPACE) begin
          phase_d  = ppmp6_pkg::PH_HEIGHT;
          height_d = '0;
          ended_d  = 1'b0;
        end else begin
          width_d = acc_next;
          ended_d = acc_ended_next;
        end
      end
      ppmp6_pkg::PH_HEIGHT: begin
        if (in_byte == ppmp6_pkg::CH_LF) begin
          phase_d = ppmp6_pkg::PH_MAXVAL;
          ended_d = 1'b0;
        end else begin
          height_d = acc_next;
          ended_d  = acc_ended_next;
        end
      end
      ppmp6_pkg::PH_MAXVAL: begin
        if (in_byte == ppmp6_pkg::CH_LF) begin
          col_d   = '0;
          row_d   = '0;
          color_d = ppmp6_pkg::CI_RED;
          if (dims_zero) begin
            phase_d  = ppmp6_pkg::PH_MAGIC0;
            width_d  = '0;
            height_d = '0;
            ended_d  = 1'b0;
          end else begin
            phase_d = ppmp6_pkg::PH_PIXELS;
          end
        end
      end
      ppmp6_pkg::PH_PIXELS: begin
        unique case (color_q)
          ppmp6_pkg::CI_RED: begin
            held_red_d = in_byte;
            color_d    = ppmp6_pkg::CI_GREEN;
          end
          ppmp6_pkg::CI_GREEN: begin
            held_green_d = in_byte;
            color_d      = ppmp6_pkg::CI_BLUE;
          end
          default: begin
            color_d = ppmp6_pkg::CI_RED;
            if (last_pix) begin
              phase_d  = ppmp6_pkg::PH_MAGIC0;
              width_d  = '0;
              height_d = '0;
              ended_d  = 1'b0;
              col_d    = '0;
              row_d    = '0;
            end else if (end_col) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        endcase
      end
      default: begin
        phase_d  = ppmp6_pkg::PH_MAGIC0;
        width_d  = '0;
        height_d = '0;
        ended_d  = 1'b0;
        col_d    = '0;
        row_d    = '0;
        color_d  = ppmp6_pkg::CI_RED;
      end
    endcase
  end

  // Result produced by the current byte.
  always_comb begin
    res_valid  = 1'b0;
    res_kind   = ppmp6_pkg::KIND_HEADER;
    res_width  = '0;
    res_height = '0;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_last   = 1'b0;
    unique case (phase_q)
      ppmp6_pkg::PH_MAGIC1: begin
        if (held_red_q != ppmp6_pkg::CH_P || in_byte != ppmp6_pkg::CH_SIX) begin
          res_valid = 1'b1;
          res_kind  = ppmp6_pkg::KIND_ERROR;
        end
      end
      ppmp6_pkg::PH_MAXVAL: begin
        if (in_byte == ppmp6_pkg::CH_LF) begin
          res_valid  = 1'b1;
          res_kind   = ppmp6_pkg::KIND_HEADER;
          res_width  = DW'(width_q);
          res_height = DW'(height_q);
        end
      end
      ppmp6_pkg::PH_PIXELS: begin
        if (color_q == ppmp6_pkg::CI_BLUE) begin
          res_valid = 1'b1;
          res_kind  = ppmp6_pkg::KIND_PIXEL;
          res_red   = held_red_q;
          res_green = held_green_q;
          res_blue  = in_byte;
          res_last  = last_pix;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ppmp6_pkg::PH_MAGIC0;
      color_q      <= ppmp6_pkg::CI_RED;
      width_q      <= '0;
      height_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      ended_q      <= 1'b0;
      held_red_q   <= '0;
      held_green_q <= '0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      color_q      <= color_d;
      width_q      <= width_d;
      height_q     <= height_d;
      col_q        <= col_d;
      row_q        <= row_d;
      ended_q      <= ended_d;
      held_red_q   <= held_red_d;
      held_green_q <= held_green_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_kind_q   <= res_kind;
      out_width_q  <= res_width;
      out_height_q <= res_height;
      out_red_q    <= res_red;
      out_green_q  <= res_green;
      out_blue_q   <= res_blue;
      out_last_q   <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_blue_q, out_green_q, out_red_q, out_height_q, out_width_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== verif/ppm_p6_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// PPM P6 header parser testbench
// Feeds the parser a stream of P6 files one byte per beat: a short table of
// hand-picked bytes first, then random well-formed files mixed with bad magic
// bytes, noise and cut-off files. A built-in model of the parser predicts
// every header, pixel and error beat, and each beat on m_axis is compared
// field by field with the oldest prediction. Both sides idle at random, the
// receiver holds off once long enough to stall the input, and the sender
// pauses until all predicted beats have arrived between phases.
// ----------------------------------------------------------------------------
module ppm_p6_header_parser_tb;

  typedef struct packed {
    ppmp6_pkg::kind_e kind;
    logic [15:0]      width;
    logic [15:0]      height;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } ppm_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    ppm_beat_t  beat;
  } stim_row_t;

  localparam ppm_beat_t NO_BEAT =
    '{ppmp6_pkg::KIND_HEADER, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0};
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned CHUNK_BYTES = 570;
  localparam int DIR_ROWS = 26;

  // Bad magic, a comment line, a saturated width with an empty image, then a
  // 1x1 image whose single pixel carries the byte extremes.
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h58,               1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_SIX,   1'b1,
      '{ppmp6_pkg::KIND_ERROR, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{ppmp6_pkg::CH_P,     1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_SIX,   1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_LF,    1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_HASH,  1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_LF,    1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_NINE,  1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_NINE,  1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_NINE,  1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_NINE,  1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_NINE,  1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_SPACE, 1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_LF,    1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_LF,    1'b1,
      '{ppmp6_pkg::KIND_HEADER, 16'hFFFF, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{ppmp6_pkg::CH_P,     1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_SIX,   1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_LF,    1'b0, NO_BEAT},
    '{8'h31,               1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_SPACE, 1'b0, NO_BEAT},
    '{8'h31,               1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_LF,    1'b0, NO_BEAT},
    '{ppmp6_pkg::CH_LF,    1'b1,
      '{ppmp6_pkg::KIND_HEADER, 16'd1, 16'd1, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{8'h00,               1'b0, NO_BEAT},
    '{8'hFF,               1'b0, NO_BEAT},
    '{8'h80,               1'b1,
      '{ppmp6_pkg::KIND_PIXEL, 16'd0, 16'd0, 8'h00, 8'hFF, 8'h80, 1'b1}}
  };

  logic                             clk_i;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // data_byte[7:0]
  logic [ppmp6_pkg::BYTE_W-1:0]     s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // image_width[15:0], image_height[31:16], red[39:32], green[47:40], blue[55:48]
  logic [ppmp6_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // kind[1:0]
  logic [ppmp6_pkg::KIND_W-1:0]     m_axis_tuser;
  logic                             m_axis_tlast;

  ppm_beat_t   pending_beats [$];
  logic [7:0]  file_q [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  ppmp6_pkg::phase_e ph;
  logic [15:0]       w_acc;
  logic [15:0]       h_acc;
  logic              dig_end;
  logic [15:0]       col_cnt;
  logic [15:0]       row_cnt;
  ppmp6_pkg::color_e color_sel;
  logic [7:0]        held_r;
  logic [7:0]        held_g;

  ppm_p6_header_parser #(
    .DIM_BITS(16)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void restart_parse();
    ph = ppmp6_pkg::PH_MAGIC0;
    w_acc = '0;
    h_acc = '0;
    dig_end = 1'b0;
    col_cnt = '0;
    row_cnt = '0;
    color_sel = ppmp6_pkg::CI_RED;
  endfunction

  // Only the leading digits count, and the value saturates at 65535.
  function automatic logic [15:0] next_dim(input logic [15:0] acc, input logic [7:0] b);
    int unsigned v;
    if (dig_end) return acc;
    if (b < ppmp6_pkg::CH_ZERO || b > ppmp6_pkg::CH_NINE) begin
      dig_end = 1'b1;
      return acc;
    end
    v = 32'(acc) * 32'd10 + 32'(b - ppmp6_pkg::CH_ZERO);
    if (v > 32'd65535) v = 32'd65535;
    return v[15:0];
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output ppm_beat_t res);
    bit emitted;
    bit end_col;
    bit end_row;
    emitted = 1'b0;
    res = NO_BEAT;
    case (ph)
      ppmp6_pkg::PH_MAGIC0: begin
        held_r = b;
        ph = ppmp6_pkg::PH_MAGIC1;
      end
      ppmp6_pkg::PH_MAGIC1: begin
        if (held_r != ppmp6_pkg::CH_P || b != ppmp6_pkg::CH_SIX) begin
          restart_parse();
          res.kind = ppmp6_pkg::KIND_ERROR;
          emitted = 1'b1;
        end else begin
          ph = ppmp6_pkg::PH_SKIP1;
        end
      end
      ppmp6_pkg::PH_SKIP1, ppmp6_pkg::PH_COMMENT: begin
        if (b == ppmp6_pkg::CH_LF) ph = ppmp6_pkg::PH_CHECK;
      end
      ppmp6_pkg::PH_CHECK: begin
        if (b == ppmp6_pkg::CH_HASH) begin
          ph = ppmp6_pkg::PH_COMMENT;
        end else begin
          w_acc = '0;
          dig_end = 1'b0;
          if (b == ppmp6_pkg::CH_SPACE) begin
            ph = ppmp6_pkg::PH_HEIGHT;
            h_acc = '0;
          end else begin
            ph = ppmp6_pkg::PH_WIDTH;
            w_acc = next_dim(w_acc, b);
          end
        end
      end
      ppmp6_pkg::PH_WIDTH: begin
        if (b == ppmp6_pkg::CH_SPACE) begin
          ph = ppmp6_pkg::PH_HEIGHT;
          h_acc = '0;
          dig_end = 1'b0;
        end else begin
          w_acc = next_dim(w_acc, b);
        end
      end
      ppmp6_pkg::PH_HEIGHT: begin
        if (b == ppmp6_pkg::CH_LF) begin
          ph = ppmp6_pkg::PH_MAXVAL;
          dig_end = 1'b0;
        end else begin
          h_acc = next_dim(h_acc, b);
        end
      end
      ppmp6_pkg::PH_MAXVAL: begin
        if (b == ppmp6_pkg::CH_LF) begin
          emitted = 1'b1;
          res.width = w_acc;
          res.height = h_acc;
          if (w_acc == 0 || h_acc == 0) begin
            restart_parse();
          end else begin
            ph = ppmp6_pkg::PH_PIXELS;
            col_cnt = '0;
            row_cnt = '0;
            color_sel = ppmp6_pkg::CI_RED;
          end
        end
      end
      ppmp6_pkg::PH_PIXELS: begin
        if (color_sel == ppmp6_pkg::CI_RED) begin
          held_r = b;
          color_sel = ppmp6_pkg::CI_GREEN;
        end else if (color_sel == ppmp6_pkg::CI_GREEN) begin
          held_g = b;
          color_sel = ppmp6_pkg::CI_BLUE;
        end else begin
          end_col = (32'(col_cnt) + 32'd1 >= 32'(w_acc));
          end_row = (32'(row_cnt) + 32'd1 >= 32'(h_acc));
          emitted = 1'b1;
          res.kind = ppmp6_pkg::KIND_PIXEL;
          res.red = held_r;
          res.green = held_g;
          res.blue = b;
          res.last = end_col && end_row;
          color_sel = ppmp6_pkg::CI_RED;
          if (end_col && end_row) begin
            restart_parse();
          end else if (end_col) begin
            col_cnt = '0;
            row_cnt = row_cnt + 16'd1;
          end else begin
            col_cnt = col_cnt + 16'd1;
          end
        end
      end
      default: restart_parse();
    endcase
    return emitted;
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] c,
                                                  input bit no_digit);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == a || b == c ||
               (no_digit && b >= ppmp6_pkg::CH_ZERO && b <= ppmp6_pkg::CH_NINE));
    return b;
  endfunction

  function automatic void add_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endfunction

  function automatic void build_image(input int unsigned w, input int unsigned h);
    file_q.push_back(ppmp6_pkg::CH_P);
    file_q.push_back(ppmp6_pkg::CH_SIX);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        file_q.push_back(rand_byte_except(ppmp6_pkg::CH_LF, ppmp6_pkg::CH_LF, 1'b0));
      end
    end
    file_q.push_back(ppmp6_pkg::CH_LF);
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        file_q.push_back(ppmp6_pkg::CH_HASH);
        repeat ($urandom_range(5)) begin
          file_q.push_back(rand_byte_except(ppmp6_pkg::CH_LF, ppmp6_pkg::CH_LF, 1'b0));
        end
        file_q.push_back(ppmp6_pkg::CH_LF);
      end
    end
    add_number(w);
    if ($urandom_range(4) == 0) begin
      file_q.push_back(rand_byte_except(ppmp6_pkg::CH_SPACE, ppmp6_pkg::CH_SPACE, 1'b1));
      repeat ($urandom_range(3)) begin
        file_q.push_back(rand_byte_except(ppmp6_pkg::CH_SPACE, ppmp6_pkg::CH_SPACE, 1'b0));
      end
    end
    file_q.push_back(ppmp6_pkg::CH_SPACE);
    add_number(h);
    if ($urandom_range(4) == 0) begin
      file_q.push_back(rand_byte_except(ppmp6_pkg::CH_LF, ppmp6_pkg::CH_LF, 1'b1));
      repeat ($urandom_range(3)) begin
        file_q.push_back(rand_byte_except(ppmp6_pkg::CH_LF, ppmp6_pkg::CH_LF, 1'b0));
      end
    end
    file_q.push_back(ppmp6_pkg::CH_LF);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(4)) begin
        file_q.push_back(rand_byte_except(ppmp6_pkg::CH_LF, ppmp6_pkg::CH_LF, 1'b0));
      end
    end else begin
      add_number(255);
    end
    file_q.push_back(ppmp6_pkg::CH_LF);
    repeat (3 * w * h) file_q.push_back(8'($urandom_range(255)));
  endfunction

  // Headers whose width or height comes out as zero.
  function automatic void build_empty();
    file_q.push_back(ppmp6_pkg::CH_P);
    file_q.push_back(ppmp6_pkg::CH_SIX);
    file_q.push_back(ppmp6_pkg::CH_LF);
    case ($urandom_range(3))
      0: begin
        add_number($urandom_range(65536, 999999));
        file_q.push_back(ppmp6_pkg::CH_SPACE);
      end
      1: begin
        file_q.push_back(ppmp6_pkg::CH_SPACE);
        add_number($urandom_range(0, 999999));
      end
      2: begin
        file_q.push_back(rand_byte_except(ppmp6_pkg::CH_HASH, ppmp6_pkg::CH_SPACE, 1'b1));
        file_q.push_back(ppmp6_pkg::CH_SPACE);
        add_number(0);
      end
      default: begin
        add_number($urandom_range(1, 9));
        file_q.push_back(ppmp6_pkg::CH_SPACE);
        add_number(0);
      end
    endcase
    file_q.push_back(ppmp6_pkg::CH_LF);
    add_number(255);
    file_q.push_back(ppmp6_pkg::CH_LF);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input ppm_beat_t typed_beat);
    ppm_beat_t beat;
    bit emitted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    emitted = parse_byte(b, beat);
    if (typed) pending_beats.push_back(typed_beat);
    else if (emitted) pending_beats.push_back(beat);
  endtask

  // Sends the built file, then pads until the parser waits for magic bytes.
  task automatic send_file();
    logic [7:0] pad;
    foreach (file_q[i]) send_byte(file_q[i], 1'b0, NO_BEAT);
    file_q.delete();
    while (ph != ppmp6_pkg::PH_MAGIC0) begin
      case (ph)
        ppmp6_pkg::PH_CHECK, ppmp6_pkg::PH_WIDTH:   pad = ppmp6_pkg::CH_SPACE;
        ppmp6_pkg::PH_MAGIC1, ppmp6_pkg::PH_PIXELS: pad = 8'($urandom_range(255));
        default:                                    pad = ppmp6_pkg::CH_LF;
      endcase
      send_byte(pad, 1'b0, NO_BEAT);
    end
  endtask

  task automatic send_random_file();
    int unsigned r;
    int unsigned w;
    int unsigned h;
    logic [7:0] b0;
    logic [7:0] b1;
    r = $urandom_range(99);
    if ($urandom_range(19) == 0) begin
      w = $urandom_range(5, 16);
      h = $urandom_range(1, 2);
    end else begin
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 4);
    end
    if (r < 8) begin
      b0 = ($urandom_range(1) == 0) ? ppmp6_pkg::CH_P : 8'($urandom_range(255));
      b1 = 8'($urandom_range(255));
      if (b0 == ppmp6_pkg::CH_P && b1 == ppmp6_pkg::CH_SIX) b1 = 8'h37;
      file_q.push_back(b0);
      file_q.push_back(b1);
    end else if (r < 12) begin
      repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(255)));
    end else if (r < 20) begin
      build_empty();
    end else if (r < 25) begin
      build_image(w, h);
      repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
    end else begin
      build_image(w, h);
    end
    send_file();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    ppm_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat, kind %0d", m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("image_width", want.width, m_axis_tdata[15:0]);
        check_field("image_height", want.height, m_axis_tdata[31:16]);
        check_field("red", want.red, m_axis_tdata[39:32]);
        check_field("green", want.green, m_axis_tdata[47:40]);
        check_field("blue", want.blue, m_axis_tdata[55:48]);
        check_field("last_pixel", want.last, m_axis_tlast);
      end
    end
  end

  initial begin
    int unsigned target;
    int unsigned wait_cycles;
    restart_parse();
    held_r = '0;
    held_g = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 68;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TAB[i].data, DIR_TAB[i].typed, DIR_TAB[i].beat);
    end
    drain();

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 28 : (m == 1) ? 68 : 0;
      recv_idle_pct = (m == 0) ? 68 : (m == 1) ? 28 : 0;
      if (m == 2) begin
        // The receiver stalls while a whole image is offered back to back.
        hold_requests++;
        build_image(4, 4);
        send_file();
      end
      target = bytes_sent + CHUNK_BYTES;
      while (bytes_sent < target) send_random_file();
      drain();
    end

    wait_cycles = 0;
    while (pending_beats.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_beats.size());
    end
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
